// File: rtl/core/wide_line_to_quad_expander_top_macros.svh
// Assertion macros shared by the expander RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef WIDE_LINE_TO_QUAD_EXPANDER_TOP_MACROS_SVH
`define WIDE_LINE_TO_QUAD_EXPANDER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LWQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LWQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/lwq_pkg.sv
// Shared constants, types and functions of the line-to-quad expander.
// Depends on nothing; used by every module of the block but lwq_fifo.
`default_nettype none

package lwq_pkg;

   // Default coordinate width, signed with 8 fractional bits.
   localparam int COORD_WIDTH_DEFAULT = 24;

   // Width of a signed side offset; its magnitude never exceeds the half width.
   localparam int OFF_W = 17;

   // Width of the normalizer working magnitudes.
   localparam int WORK_W = 32;

   // Configuration address width and register indexes.
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_ENABLE     = 2'd0;
   localparam logic [1:0] REG_HALF_WIDTH = 2'd1;
   localparam logic [1:0] REG_MIN_LENGTH = 2'd2;
   localparam logic [1:0] REG_ALPHA      = 2'd3;

   // Register reset values.
   localparam logic        ENABLE_RST     = 1'b0;
   localparam logic [15:0] HALF_WIDTH_RST = 16'd384;
   localparam logic [15:0] MIN_LENGTH_RST = 16'd3;
   localparam logic [7:0]  ALPHA_RST      = 8'd200;

   // Color bytes of one segment.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   // Unorm color (256 is 1.0) to a byte: floor(c * 255 / 256), saturated.
   function automatic logic [7:0] to_byte(input logic [8:0] c);
      logic [16:0] prod;
      prod = {c, 8'h00} - 17'(c);
      to_byte = (prod[16]) ? 8'hFF : prod[15:8];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/lwq_fifo.sv
// Two-entry queue between the segment classifier and the normalizer.
// Depends on nothing beyond its width parameter.
`default_nettype none

module lwq_fifo #(
   parameter int DW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [DW-1:0] wr_data,
   output logic               full,
   input  wire logic          rd_en,
   output logic [DW-1:0]      rd_data,
   output logic               empty
);

   logic [DW-1:0] mem_ff [2];
   logic          wp_ff, wp_in;
   logic          rp_ff, rp_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          do_wr, do_rd;

   // Pointer and fill bookkeeping.
   always_comb begin
      full  = (cnt_ff == 2'd2);
      empty = (cnt_ff == 2'd0);
      do_wr = wr_en && !full;
      do_rd = rd_en && !empty;
      wp_in = do_wr ? !wp_ff : wp_ff;
      rp_in = do_rd ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(do_wr) - 2'(do_rd);
      rd_data = mem_ff[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/lwq_front.sv
// Front end: registers a segment, drops disabled and short ones and picks the side axis.
// Depends on lwq_pkg.
`default_nettype none

module lwq_front #(
   parameter int W = lwq_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output logic                     full,
   input  wire logic signed [W-1:0] start_x,
   input  wire logic signed [W-1:0] start_y,
   input  wire logic signed [W-1:0] start_z,
   input  wire logic signed [W-1:0] end_x,
   input  wire logic signed [W-1:0] end_y,
   input  wire logic signed [W-1:0] end_z,
   input  wire logic [8:0]          color_red,
   input  wire logic [8:0]          color_green,
   input  wire logic [8:0]          color_blue,
   input  wire logic                enable,
   input  wire logic [15:0]         min_length,
   input  wire logic                fifo_full,
   output logic                     fifo_push,
   output logic [3*W-1:0]           job_p0,
   output logic [3*W-1:0]           job_p1,
   output logic signed [W:0]        job_a,
   output logic signed [W:0]        job_b,
   output logic                     job_fb,
   output lwq_pkg::color_type       job_color
);

   logic                v_ff, v_in;
   logic signed [W-1:0] s_ff [3];
   logic signed [W-1:0] e_ff [3];
   logic [8:0]          c_ff [3];
   logic                load;
   logic signed [W:0]   d [3];
   logic [W:0]          mag [3];
   logic [2:0]          fits16;
   logic [31:0]         sq [3];
   logic [33:0]         sum2, sum3, lim2;
   logic                short2, short3, drop, advance;

   // Deltas, magnitudes and squared lengths of the held word.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         d[j]      = {e_ff[j][W-1], e_ff[j]} - {s_ff[j][W-1], s_ff[j]};
         mag[j]    = d[j][W] ? (W+1)'(-d[j]) : (W+1)'(d[j]);
         fits16[j] = (mag[j][W:16] == '0);
         sq[j]     = mag[j][15:0] * mag[j][15:0];
      end
      sum2   = 34'(sq[0]) + 34'(sq[1]);
      sum3   = sum2 + 34'(sq[2]);
      lim2   = 34'(min_length * min_length);
      short2 = fits16[0] && fits16[1] && (sum2 < lim2);
      short3 = (&fits16) && (sum3 < lim2);
      drop   = !enable || short3;
   end

   // Handshake: the held word leaves when dropped or when the queue has room.
   always_comb begin
      advance   = v_ff && (drop || !fifo_full);
      full      = v_ff && !advance;
      load      = push && !full;
      fifo_push = v_ff && !drop && !fifo_full;
      v_in      = load || (v_ff && !advance);
   end

   // Job word for the normalizer.
   always_comb begin
      job_p0    = {s_ff[2], s_ff[1], s_ff[0]};
      job_p1    = {e_ff[2], e_ff[1], e_ff[0]};
      job_fb    = short2;
      job_a     = short2 ? d[2] : d[1];
      job_b     = short2 ? -d[1] : -d[0];
      job_color.red   = lwq_pkg::to_byte(c_ff[0]);
      job_color.green = lwq_pkg::to_byte(c_ff[1]);
      job_color.blue  = lwq_pkg::to_byte(c_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s_ff[0] <= start_x;
         s_ff[1] <= start_y;
         s_ff[2] <= start_z;
         e_ff[0] <= end_x;
         e_ff[1] <= end_y;
         e_ff[2] <= end_z;
         c_ff[0] <= color_red;
         c_ff[1] <= color_green;
         c_ff[2] <= color_blue;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/lwq_norm.sv
// Normalizer: scales the side vector to the half width with a shift unit,
// a bit-serial square root and two restoring dividers. Depends on lwq_pkg.
`default_nettype none

module lwq_norm #(
   parameter int W = lwq_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [15:0]                   half_width,
   input  wire logic                          in_valid,
   output logic                               in_pop,
   input  wire logic [3*W-1:0]                in_p0,
   input  wire logic [3*W-1:0]                in_p1,
   input  wire logic signed [W:0]             in_a,
   input  wire logic signed [W:0]             in_b,
   input  wire logic                          in_fb,
   input  wire lwq_pkg::color_type            in_color,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [3*W-1:0]                     out_p0,
   output logic [3*W-1:0]                     out_p1,
   output logic signed [lwq_pkg::OFF_W-1:0]   out_off_x,
   output logic signed [lwq_pkg::OFF_W-1:0]   out_off_y,
   output logic signed [lwq_pkg::OFF_W-1:0]   out_off_z,
   output lwq_pkg::color_type                 out_color
);

   localparam int WW = lwq_pkg::WORK_W;
   localparam int OW = lwq_pkg::OFF_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SHIFT, ST_SQR, ST_ROOT, ST_MUL, ST_DIV, ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [3*W-1:0]     p0_ff, p0_in, p1_ff, p1_in;
   logic               fb_ff, fb_in, neg_a_ff, neg_a_in, neg_b_ff, neg_b_in;
   lwq_pkg::color_type color_ff, color_in;
   logic [WW-1:0]      ma_ff, ma_in, mb_ff, mb_in;
   logic [61:0]        rem_ff, rem_in, root_ff, root_in;
   logic [4:0]         idx_ff, idx_in;
   logic [31:0]        den_ff, den_in, ra_ff, ra_in, rb_ff, rb_in;
   logic [15:0]        na_ff, na_in, nb_ff, nb_in, qa_ff, qa_in, qb_ff, qb_in;
   logic [3:0]         cnt_ff, cnt_in;

   logic [W:0]         mag_a, mag_b;
   logic [WW-1:0]      m;
   logic [59:0]        sqa, sqb;
   logic [61:0]        bitv, trial;
   logic [45:0]        pa, pb;
   logic [47:0]        numa, numb;
   logic [32:0]        ta, tb;
   logic signed [OW-1:0] off_a, off_b;

   // Next-state logic of the normalizer.
   always_comb begin
      state_in = state_ff;
      p0_in = p0_ff;  p1_in = p1_ff;  fb_in = fb_ff;  color_in = color_ff;
      neg_a_in = neg_a_ff;  neg_b_in = neg_b_ff;
      ma_in = ma_ff;  mb_in = mb_ff;  rem_in = rem_ff;  root_in = root_ff;
      idx_in = idx_ff;  den_in = den_ff;  ra_in = ra_ff;  rb_in = rb_ff;
      na_in = na_ff;  nb_in = nb_ff;  qa_in = qa_ff;  qb_in = qb_ff;
      cnt_in = cnt_ff;
      in_pop = 1'b0;

      mag_a = in_a[W] ? (W+1)'(-in_a) : (W+1)'(in_a);
      mag_b = in_b[W] ? (W+1)'(-in_b) : (W+1)'(in_b);
      m     = (ma_ff > mb_ff) ? ma_ff : mb_ff;
      sqa   = ma_ff[29:0] * ma_ff[29:0];
      sqb   = mb_ff[29:0] * mb_ff[29:0];
      bitv  = 62'(1) << {idx_ff, 1'b0};
      trial = root_ff + bitv;
      pa    = ma_ff[29:0] * half_width;
      pb    = mb_ff[29:0] * half_width;
      numa  = 48'({pa, 1'b0}) + 48'(root_ff[30:0]);
      numb  = 48'({pb, 1'b0}) + 48'(root_ff[30:0]);
      ta    = {ra_ff, na_ff[15]};
      tb    = {rb_ff, nb_ff[15]};

      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               in_pop   = 1'b1;
               p0_in    = in_p0;
               p1_in    = in_p1;
               fb_in    = in_fb;
               color_in = in_color;
               neg_a_in = in_a[W];
               neg_b_in = in_b[W];
               ma_in    = WW'(mag_a[W-1:0]);
               mb_in    = WW'(mag_b[W-1:0]);
               state_in = ST_SHIFT;
            end
         end
         // Bring the larger magnitude into [2^29, 2^30).
         ST_SHIFT: begin
            if (m == '0) begin
               qa_in    = '0;
               qb_in    = '0;
               state_in = ST_DONE;
            end else if (m[WW-1:30] != '0) begin
               ma_in = ma_ff >> 1;
               mb_in = mb_ff >> 1;
            end else if (m[WW-1:21] == '0) begin
               ma_in = ma_ff << 8;
               mb_in = mb_ff << 8;
            end else if (!m[29]) begin
               ma_in = ma_ff << 1;
               mb_in = mb_ff << 1;
            end else begin
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            rem_in   = 62'(sqa) + 62'(sqb);
            root_in  = '0;
            idx_in   = 5'd30;
            state_in = ST_ROOT;
         end
         // One result bit of the integer square root per cycle.
         ST_ROOT: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bitv;
            end else begin
               root_in = root_ff >> 1;
            end
            if (idx_ff == '0) begin
               state_in = ST_MUL;
            end else begin
               idx_in = idx_ff - 5'd1;
            end
         end
         ST_MUL: begin
            ra_in    = numa[47:16];
            na_in    = numa[15:0];
            rb_in    = numb[47:16];
            nb_in    = numb[15:0];
            den_in   = {root_ff[30:0], 1'b0};
            qa_in    = '0;
            qb_in    = '0;
            cnt_in   = 4'd15;
            state_in = ST_DIV;
         end
         // One quotient bit of each rounded offset per cycle.
         ST_DIV: begin
            if (ta >= 33'(den_ff)) begin
               ra_in = 32'(ta - 33'(den_ff));
               qa_in = {qa_ff[14:0], 1'b1};
            end else begin
               ra_in = ta[31:0];
               qa_in = {qa_ff[14:0], 1'b0};
            end
            if (tb >= 33'(den_ff)) begin
               rb_in = 32'(tb - 33'(den_ff));
               qb_in = {qb_ff[14:0], 1'b1};
            end else begin
               rb_in = tb[31:0];
               qb_in = {qb_ff[14:0], 1'b0};
            end
            na_in = na_ff << 1;
            nb_in = nb_ff << 1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 4'd1;
            end
         end
         ST_DONE: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Signed offsets placed on the chosen axes.
   always_comb begin
      off_a = neg_a_ff ? -$signed({1'b0, qa_ff}) : $signed({1'b0, qa_ff});
      off_b = neg_b_ff ? -$signed({1'b0, qb_ff}) : $signed({1'b0, qb_ff});
      out_valid = (state_ff == ST_DONE);
      out_p0    = p0_ff;
      out_p1    = p1_ff;
      out_color = color_ff;
      out_off_x = fb_ff ? '0 : off_a;
      out_off_y = fb_ff ? off_a : off_b;
      out_off_z = fb_ff ? off_b : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      p0_ff <= p0_in;  p1_ff <= p1_in;  fb_ff <= fb_in;  color_ff <= color_in;
      neg_a_ff <= neg_a_in;  neg_b_ff <= neg_b_in;
      ma_ff <= ma_in;  mb_ff <= mb_in;  rem_ff <= rem_in;  root_ff <= root_in;
      idx_ff <= idx_in;  den_ff <= den_in;  ra_ff <= ra_in;  rb_ff <= rb_in;
      na_ff <= na_in;  nb_ff <= nb_in;  qa_ff <= qa_in;  qb_ff <= qb_in;
      cnt_ff <= cnt_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/lwq_emit.sv
// Vertex stage: holds one quad and sends its four vertices, one word each.
// Depends on lwq_pkg and the assertion macro header.
`default_nettype none
`include "wide_line_to_quad_expander_top_macros.svh"

module lwq_emit #(
   parameter int W = lwq_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             job_valid,
   output logic                                  job_take,
   input  wire logic [3*W-1:0]                   job_p0,
   input  wire logic [3*W-1:0]                   job_p1,
   input  wire logic signed [lwq_pkg::OFF_W-1:0] job_off_x,
   input  wire logic signed [lwq_pkg::OFF_W-1:0] job_off_y,
   input  wire logic signed [lwq_pkg::OFF_W-1:0] job_off_z,
   input  wire lwq_pkg::color_type               job_color,
   input  wire logic [7:0]                       alpha_value,
   output logic                                  empty,
   input  wire logic                             pop,
   output logic signed [W-1:0]                   vert_x,
   output logic signed [W-1:0]                   vert_y,
   output logic signed [W-1:0]                   vert_z,
   output logic                                  tex_s,
   output logic                                  tex_t,
   output logic [7:0]                            out_red,
   output logic [7:0]                            out_green,
   output logic [7:0]                            out_blue,
   output logic [7:0]                            out_alpha,
   output logic                                  last_vertex
);

   localparam logic signed [W+1:0] HI = $signed({3'b000, {(W-1){1'b1}}});
   localparam logic signed [W+1:0] LO = $signed({3'b111, {(W-1){1'b0}}});

   logic                busy_ff, busy_in;
   logic [1:0]          k_ff, k_in;
   logic [3*W-1:0]      p0_ff, p1_ff, base_vec;
   logic signed [lwq_pkg::OFF_W-1:0] off_ff [3];
   lwq_pkg::color_type  color_ff;
   logic                done_word, plus;
   logic signed [W-1:0] base;
   logic signed [W+1:0] sum;
   logic signed [W-1:0] vert [3];

   // Word sequencing: a new quad loads when idle or as the last word leaves.
   always_comb begin
      empty     = !busy_ff;
      done_word = pop && busy_ff;
      job_take  = job_valid && (!busy_ff || (done_word && (k_ff == 2'd3)));
      busy_in   = busy_ff;
      k_in      = k_ff;
      if (done_word) begin
         if (k_ff == 2'd3) begin
            busy_in = job_take;
            k_in    = 2'd0;
         end else begin
            k_in = k_ff + 2'd1;
         end
      end else if (job_take) begin
         busy_in = 1'b1;
         k_in    = 2'd0;
      end
   end

   // Corner coordinates with saturation.
   always_comb begin
      plus     = k_ff[1] ^ k_ff[0];
      base_vec = k_ff[1] ? p1_ff : p0_ff;
      base     = '0;
      sum      = '0;
      for (int j = 0; j < 3; j++) begin
         base = $signed(base_vec[j*W +: W]);
         sum  = plus ? (W+2)'(base) + (W+2)'(off_ff[j])
                     : (W+2)'(base) - (W+2)'(off_ff[j]);
         if (sum > HI) begin
            vert[j] = HI[W-1:0];
         end else if (sum < LO) begin
            vert[j] = LO[W-1:0];
         end else begin
            vert[j] = sum[W-1:0];
         end
      end
      vert_x      = vert[0];
      vert_y      = vert[1];
      vert_z      = vert[2];
      tex_s       = k_ff[1];
      tex_t       = plus;
      out_red     = color_ff.red;
      out_green   = color_ff.green;
      out_blue    = color_ff.blue;
      out_alpha   = alpha_value;
      last_vertex = (k_ff == 2'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         p0_ff     <= job_p0;
         p1_ff     <= job_p1;
         off_ff[0] <= job_off_x;
         off_ff[1] <= job_off_y;
         off_ff[2] <= job_off_z;
         color_ff  <= job_color;
      end
   end

   // A quad is only replaced once its fourth word has gone.
   `LWQ_ASSERT_NOW(a_take_when_free, clock, reset, job_take, !busy_ff || (done_word && k_ff == 2'd3), "quad overwritten early")
   // A word other than the fourth keeps the queue side non-empty.
   `LWQ_ASSERT_NEXT(a_mid_quad_busy, clock, reset, done_word && k_ff != 2'd3, busy_ff && k_ff == $past(k_ff) + 2'd1, "quad cut short")
   // After the fourth word with nothing waiting the stage is empty.
   `LWQ_ASSERT_NEXT(a_drain, clock, reset, done_word && k_ff == 2'd3 && !job_valid, !busy_ff, "stale quad repeated")

endmodule

`default_nettype wire

// File: rtl/core/wide_line_to_quad_expander_top.sv
// Wide line to quad expander: a 3D segment in, four quad vertices out.
// Input side is a queue write port (push/full), output a queue read port
// (empty/pop), configuration an APB-style register port with pready tied high.
// A segment is taken whenever full is low; full rises only while the front
// register waits for room in the two-entry queue ahead of the normalizer.
// Disabled or short segments are dropped in the front and give no words.
// Each kept segment passes the normalizer: a load step, the shift steps, a
// square, the square-root steps, a multiply and the divide steps, then a
// hand-off; the normalizer takes the next segment only after that hand-off,
// so it sets the sustained rate. A zero side vector skips the arithmetic,
// and the four words then set the rate. The four vertices leave one per
// cycle as long as pop stays high, while the next segment is already being
// normalized. If the receiver holds off pop, the vertex stage holds its
// quad, the normalizer waits in its done step, and full rises once the
// queue fills. Reset is synchronous: it empties every stage and returns the
// registers to enable 0, half width 384, minimum length 3 and alpha 200.
// Depends on lwq_pkg, lwq_front, lwq_fifo, lwq_norm and lwq_emit.
`default_nettype none

module wide_line_to_quad_expander_top #(
   parameter int COORD_WIDTH = lwq_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic signed [COORD_WIDTH-1:0] req_start_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_start_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_start_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_end_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_end_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_end_z,
   input  wire logic [8:0]                    req_color_red,
   input  wire logic [8:0]                    req_color_green,
   input  wire logic [8:0]                    req_color_blue,
   output logic                               empty,
   input  wire logic                          pop,
   output logic signed [COORD_WIDTH-1:0]      rsp_vert_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_vert_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_vert_z,
   output logic                               rsp_tex_s,
   output logic                               rsp_tex_t,
   output logic [7:0]                         rsp_out_red,
   output logic [7:0]                         rsp_out_green,
   output logic [7:0]                         rsp_out_blue,
   output logic [7:0]                         rsp_out_alpha,
   output logic                               rsp_last_vertex,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [lwq_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   localparam int W     = COORD_WIDTH;
   localparam int JOB_W = 6*W + 2*(W+1) + 1 + $bits(lwq_pkg::color_type);

   logic                enable_ff, enable_in;
   logic [15:0]         half_width_ff, half_width_in;
   logic [15:0]         min_length_ff, min_length_in;
   logic [7:0]          alpha_ff, alpha_in;
   logic                csr_wr;
   logic [1:0]          csr_idx;

   logic                fifo_push, fifo_full, fifo_empty, fifo_pop;
   logic [JOB_W-1:0]    fifo_wdata, fifo_rdata;
   logic [3*W-1:0]      f_p0, f_p1, q_p0, q_p1, n_p0, n_p1;
   logic signed [W:0]   f_a, f_b, q_a, q_b;
   logic                f_fb, q_fb;
   lwq_pkg::color_type  f_color, q_color, n_color;
   logic                n_valid, n_take;
   logic signed [lwq_pkg::OFF_W-1:0] n_off_x, n_off_y, n_off_z;

   // Configuration registers.
   always_comb begin
      pready        = 1'b1;
      csr_wr        = psel && penable && pwrite && pready;
      csr_idx       = paddr[3:2];
      enable_in     = enable_ff;
      half_width_in = half_width_ff;
      min_length_in = min_length_ff;
      alpha_in      = alpha_ff;
      prdata        = '0;
      unique case (csr_idx)
         lwq_pkg::REG_ENABLE:     prdata = {31'd0, enable_ff};
         lwq_pkg::REG_HALF_WIDTH: prdata = {16'd0, half_width_ff};
         lwq_pkg::REG_MIN_LENGTH: prdata = {16'd0, min_length_ff};
         lwq_pkg::REG_ALPHA:      prdata = {24'd0, alpha_ff};
         default:                 prdata = '0;
      endcase
      if (csr_wr) begin
         unique case (csr_idx)
            lwq_pkg::REG_ENABLE:     enable_in     = pwdata[0];
            lwq_pkg::REG_HALF_WIDTH: half_width_in = pwdata[15:0];
            lwq_pkg::REG_MIN_LENGTH: min_length_in = pwdata[15:0];
            lwq_pkg::REG_ALPHA:      alpha_in      = pwdata[7:0];
            default:                 enable_in     = enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= lwq_pkg::ENABLE_RST;
         half_width_ff <= lwq_pkg::HALF_WIDTH_RST;
         min_length_ff <= lwq_pkg::MIN_LENGTH_RST;
         alpha_ff      <= lwq_pkg::ALPHA_RST;
      end else begin
         enable_ff     <= enable_in;
         half_width_ff <= half_width_in;
         min_length_ff <= min_length_in;
         alpha_ff      <= alpha_in;
      end
   end

   // Classifier.
   lwq_front #(.W(W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .start_x     (req_start_x),
      .start_y     (req_start_y),
      .start_z     (req_start_z),
      .end_x       (req_end_x),
      .end_y       (req_end_y),
      .end_z       (req_end_z),
      .color_red   (req_color_red),
      .color_green (req_color_green),
      .color_blue  (req_color_blue),
      .enable      (enable_ff),
      .min_length  (min_length_ff),
      .fifo_full   (fifo_full),
      .fifo_push   (fifo_push),
      .job_p0      (f_p0),
      .job_p1      (f_p1),
      .job_a       (f_a),
      .job_b       (f_b),
      .job_fb      (f_fb),
      .job_color   (f_color)
   );

   // Job queue between the front and the normalizer.
   assign fifo_wdata = {f_color, f_fb, f_b, f_a, f_p1, f_p0};
   assign {q_color, q_fb, q_b, q_a, q_p1, q_p0} = fifo_rdata;

   lwq_fifo #(.DW(JOB_W)) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fifo_push),
      .wr_data (fifo_wdata),
      .full    (fifo_full),
      .rd_en   (fifo_pop),
      .rd_data (fifo_rdata),
      .empty   (fifo_empty)
   );

   lwq_norm #(.W(W)) u_norm (
      .clock      (clock),
      .reset      (reset),
      .half_width (half_width_ff),
      .in_valid   (!fifo_empty),
      .in_pop     (fifo_pop),
      .in_p0      (q_p0),
      .in_p1      (q_p1),
      .in_a       (q_a),
      .in_b       (q_b),
      .in_fb      (q_fb),
      .in_color   (q_color),
      .out_valid  (n_valid),
      .out_ready  (n_take),
      .out_p0     (n_p0),
      .out_p1     (n_p1),
      .out_off_x  (n_off_x),
      .out_off_y  (n_off_y),
      .out_off_z  (n_off_z),
      .out_color  (n_color)
   );

   lwq_emit #(.W(W)) u_emit (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (n_valid),
      .job_take    (n_take),
      .job_p0      (n_p0),
      .job_p1      (n_p1),
      .job_off_x   (n_off_x),
      .job_off_y   (n_off_y),
      .job_off_z   (n_off_z),
      .job_color   (n_color),
      .alpha_value (alpha_ff),
      .empty       (empty),
      .pop         (pop),
      .vert_x      (rsp_vert_x),
      .vert_y      (rsp_vert_y),
      .vert_z      (rsp_vert_z),
      .tex_s       (rsp_tex_s),
      .tex_t       (rsp_tex_t),
      .out_red     (rsp_out_red),
      .out_green   (rsp_out_green),
      .out_blue    (rsp_out_blue),
      .out_alpha   (rsp_out_alpha),
      .last_vertex (rsp_last_vertex)
   );

endmodule

`default_nettype wire
